[design/pct_pkg.sv]
package pct_pkg;

  localparam int SLOT_COUNT_DEF = 32;
  localparam int TAG_WIDTH_DEF  = 16;
  localparam int MAX_RESULTS    = 64;
  localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
  localparam int ELAPSED_W      = 48;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int IN_DATA_W      = 208;
  localparam int IN_USED_W      = 202;
  localparam int OUT_DATA_W     = 128;

  localparam logic [2:0] A_REGISTER = 3'd0;
  localparam logic [2:0] A_RESERVE  = 3'd1;
  localparam logic [2:0] A_COMMIT   = 3'd2;
  localparam logic [2:0] A_RELEASE  = 3'd3;
  localparam logic [2:0] A_REPORT   = 3'd4;
  localparam logic [2:0] A_DEFAULT  = 3'd5;
  localparam logic [2:0] A_TICK     = 3'd6;

  localparam logic [1:0] K_REPLY = 2'd0;
  localparam logic [1:0] K_EVENT = 2'd1;
  localparam logic [1:0] K_PROBE = 2'd2;

  localparam logic [1:0] ST_COMPLETED = 2'd0;
  localparam logic [1:0] ST_DELIVERED = 2'd1;
  localparam logic [1:0] ST_FAILED    = 2'd2;
  localparam logic [1:0] ST_TIMEOUT   = 2'd3;

  localparam logic [2:0] VT_U8   = 3'd0;
  localparam logic [2:0] VT_U16  = 3'd1;
  localparam logic [2:0] VT_U32  = 3'd2;
  localparam logic [2:0] VT_BOOL = 3'd4;
  localparam logic [2:0] VT_S16  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_FIRST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_RETRY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP       = 2'd2;

  localparam logic [CFG_W-1:0] PROBE_FIRST_RST = 16'd400;
  localparam logic [CFG_W-1:0] PROBE_RETRY_RST = 16'd1500;
  localparam logic [CFG_W-1:0] SWEEP_RST       = 16'd1000;

  localparam logic [15:0] ANY_ATTR      = 16'hFFFF;
  localparam logic [15:0] CL_COLOUR     = 16'h0300;
  localparam logic [15:0] ATTR_COLOUR_X = 16'h0008;
  localparam logic [15:0] ATTR_DEFAULT  = 16'h0000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] attr;
    logic [15:0] cluster;
    logic [7:0]  endpoint;
    logic [63:0] device;
    logic [15:0] tag;
    logic [4:0]  slot;
    logic        ok;
    logic [1:0]  status;
  } res_t;

  function automatic logic [31:0] extract_value(input logic [31:0] raw,
                                                input logic [2:0] vt);
    logic [31:0] v;
    case (vt)
      VT_U8:   v = {24'd0, raw[7:0]};
      VT_U16:  v = {16'd0, raw[15:0]};
      VT_U32:  v = raw;
      VT_BOOL: v = {31'd0, (raw[7:0] != 8'd0)};
      VT_S16:  v = {{16{raw[15]}}, raw[15:0]};
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/pct_mod.sv]
module pct_mod #(
  parameter int NUM_W = pct_pkg::ELAPSED_W,
  parameter int DEN_W = pct_pkg::CFG_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic             rem_zero
);

  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             ge;

  // one quotient bit a cycle, restoring
  assign trial    = {rem, num_sh[NUM_W-1]};
  assign ge       = trial >= {1'b0, den_r};
  assign rem_zero = (rem == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy   <= 1'b1;
        done   <= 1'b0;
        cnt    <= '0;
        num_sh <= num;
        den_r  <= den;
        rem    <= '0;
      end else if (busy) begin
        rem    <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        num_sh <= {num_sh[NUM_W-2:0], 1'b0};
        cnt    <= cnt + 1'b1;
        done   <= (cnt == LAST_STEP);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

[design/pending_command_tracker.sv]
// flow: register/reserve search the slots for a free one, commit/release act on
//   the named slot, report/default walk the slots, tick runs the remainder unit then walks the slots
// throughput: one transaction at a time; the slot walk reads each slot from the
//   slot memory, then evaluates it, and the sweep check runs a 48-step remainder unit
// results leave through one output register, with extra cycles under backpressure
// reset: synchronous, clears slot flags, elapsed time and restores register defaults
module pending_command_tracker #(
  parameter int SLOT_COUNT = pct_pkg::SLOT_COUNT_DEF,
  parameter int TAG_WIDTH  = pct_pkg::TAG_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // slot_index, tag, device_addr, endpoint, cluster, attr, flags, value,
  // value_type, expiry_ms, resp_status
  input  logic [pct_pkg::IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [2:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, ok, slot_index_res, tag_res, device_addr_res, endpoint_res,
  // cluster_res, attr_res
  output logic [pct_pkg::OUT_DATA_W-1:0] m_tdata,
  // kind
  output logic [1:0]                     m_tuser,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [pct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pct_pkg::CFG_W-1:0]      cfg_data
);

  import pct_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  typedef struct packed {
    logic [TAG_WIDTH-1:0] tag;
    logic [63:0]          device;
    logic [7:0]           endpoint;
    logic [15:0]          cluster;
    logic [15:0]          attr;
    logic [15:0]          probe_attr;
    logic                 check;
    logic [31:0]          expected;
    logic [ELAPSED_W-1:0] deadline;
  } entry_t;

  logic [2:0]            state;
  logic [SLOT_W-1:0]     idx;
  logic                  probe_pass;
  logic [RES_CNT_W-1:0]  res_cnt;
  logic                  mod_go;
  logic [ELAPSED_W-1:0]  elapsed;
  logic [CFG_W-1:0]      probe_first;
  logic [CFG_W-1:0]      probe_retry;
  logic [CFG_W-1:0]      sweep_period;

  logic [2:0]            act_r;
  logic [IN_USED_W-1:0]  in_r;

  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] slot_reserved;
  logic [SLOT_COUNT-1:0] slot_armed;

  entry_t                entry_mem [SLOT_COUNT];
  logic [15:0]           left_mem  [SLOT_COUNT];
  entry_t                rd_entry;
  logic [15:0]           rd_left;

  res_t                  held;
  logic                  held_valid;
  res_t                  out_r;
  logic                  out_last;
  logic                  m_valid;

  logic [4:0]            in_slot;
  logic [15:0]           in_tag;
  logic [63:0]           in_dev;
  logic [7:0]            in_ep;
  logic [15:0]           in_cl;
  logic [15:0]           in_attr;
  logic [1:0]            in_flags;
  logic [31:0]           in_value;
  logic [2:0]            in_vtype;
  logic [31:0]           in_timeout;
  logic [7:0]            in_zcl;
  logic [31:0]           rep_val;

  logic [SLOT_W-1:0]     in_addr;
  logic                  in_slot_ok;
  logic                  find_free;
  logic                  live;
  logic                  commit_we;
  logic [SLOT_W-1:0]     commit_addr;
  entry_t                wr_entry;
  logic                  left_we;
  logic [SLOT_W-1:0]     left_addr;
  logic [15:0]           left_wdata;
  logic                  ev_hit;
  logic                  ev_free;
  logic                  ev_left_we;
  logic [15:0]           ev_left;
  res_t                  ev_res;
  res_t                  reply_res;
  logic                  out_free;
  logic                  advance;
  logic                  push;
  logic                  out_load;
  logic                  mod_done;
  logic                  mod_zero;
  logic [CFG_W-1:0]      period;

  assign in_slot    = in_r[4:0];
  assign in_tag     = in_r[20:5];
  assign in_dev     = in_r[84:21];
  assign in_ep      = in_r[92:85];
  assign in_cl      = in_r[108:93];
  assign in_attr    = in_r[124:109];
  assign in_flags   = in_r[126:125];
  assign in_value   = in_r[158:127];
  assign in_vtype   = in_r[161:159];
  assign in_timeout = in_r[193:162];
  assign in_zcl     = in_r[201:194];
  assign rep_val    = extract_value(in_value, in_vtype);

  assign in_addr    = SLOT_W'(in_slot);
  assign in_slot_ok = (int'(in_slot) < SLOT_COUNT);
  assign find_free  = !slot_active[idx];
  assign live       = slot_active[idx] && !slot_reserved[idx];
  assign period     = (sweep_period == '0) ? CFG_W'(1) : sweep_period;

  assign s_tready   = (state == S_IDLE);
  assign m_tvalid   = m_valid;
  assign m_tdata    = out_r[OUT_DATA_W-1:0];
  assign m_tuser    = out_r.kind;
  assign m_tlast    = out_last;
  assign out_free   = !m_valid || m_tready;

  pct_mod #(
    .NUM_W (ELAPSED_W),
    .DEN_W (CFG_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_go),
    .num      (elapsed),
    .den      (period),
    .done     (mod_done),
    .rem_zero (mod_zero)
  );

  always_comb begin
    wr_entry.tag        = TAG_WIDTH'(in_tag);
    wr_entry.device     = in_dev;
    wr_entry.endpoint   = in_ep;
    wr_entry.cluster    = in_cl;
    wr_entry.attr       = in_attr;
    wr_entry.probe_attr = (in_attr != ANY_ATTR) ? in_attr :
                          ((in_cl == CL_COLOUR) ? ATTR_COLOUR_X : ATTR_DEFAULT);
    wr_entry.check      = in_flags[1];
    wr_entry.expected   = in_value;
    wr_entry.deadline   = elapsed + {{(ELAPSED_W-32){1'b0}}, in_timeout};

    commit_we   = 1'b0;
    commit_addr = idx;
    if (state == S_FIND && find_free && act_r == A_REGISTER) begin
      commit_we = 1'b1;
    end else if (state == S_COMMIT && act_r == A_COMMIT && in_slot_ok &&
                 slot_active[in_addr] && slot_reserved[in_addr]) begin
      commit_we   = 1'b1;
      commit_addr = in_addr;
    end

    reply_res      = '0;
    reply_res.kind = K_REPLY;
    reply_res.ok   = find_free;
    reply_res.slot = find_free ? 5'(idx) : 5'd0;

    ev_res         = '0;
    ev_res.kind    = K_EVENT;
    ev_res.slot    = 5'(idx);
    ev_res.tag     = 16'(rd_entry.tag);
    ev_res.device  = rd_entry.device;
    ev_res.cluster = rd_entry.cluster;
    ev_hit     = 1'b0;
    ev_free    = 1'b0;
    ev_left_we = 1'b0;
    ev_left    = rd_left - 16'd1;
    if (state == S_EVAL && live) begin
      case (act_r)
        A_REPORT: begin
          ev_hit = (rd_entry.device == in_dev) && (rd_entry.cluster == in_cl) &&
                   ((rd_entry.attr == ANY_ATTR) || (rd_entry.attr == in_attr)) &&
                   (!rd_entry.check || (rep_val == rd_entry.expected));
          ev_free       = ev_hit;
          ev_res.status = ST_COMPLETED;
        end
        A_DEFAULT: begin
          ev_hit        = (rd_entry.device == in_dev) && (rd_entry.cluster == in_cl);
          ev_free       = ev_hit && (in_zcl != 8'd0);
          ev_res.status = (in_zcl == 8'd0) ? ST_DELIVERED : ST_FAILED;
        end
        A_TICK: begin
          if (!probe_pass) begin
            ev_hit        = (elapsed >= rd_entry.deadline);
            ev_free       = ev_hit;
            ev_res.status = ST_TIMEOUT;
          end else if (slot_armed[idx]) begin
            ev_left_we = 1'b1;
            if (rd_left <= 16'd1) begin
              ev_hit          = 1'b1;
              ev_left         = probe_retry;
              ev_res          = '0;
              ev_res.kind     = K_PROBE;
              ev_res.slot     = 5'(idx);
              ev_res.device   = rd_entry.device;
              ev_res.endpoint = rd_entry.endpoint;
              ev_res.cluster  = rd_entry.cluster;
              ev_res.attr     = rd_entry.probe_attr;
            end
          end
        end
        default: ev_hit = 1'b0;
      endcase
    end

    advance    = !(ev_hit && held_valid && !out_free);
    push       = ev_hit && advance;
    out_load   = (state == S_EVAL && push && held_valid) ||
                 (state == S_FLUSH && held_valid && out_free);

    left_we    = commit_we || (ev_left_we && advance);
    left_addr  = commit_we ? commit_addr : idx;
    left_wdata = commit_we ? probe_first : ev_left;
  end

  always_ff @(posedge clk) begin
    if (commit_we) begin
      entry_mem[commit_addr] <= wr_entry;
    end
    if (left_we) begin
      left_mem[left_addr] <= left_wdata;
    end
    rd_entry <= entry_mem[idx];
    rd_left  <= left_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      probe_pass    <= 1'b0;
      res_cnt       <= '0;
      mod_go        <= 1'b0;
      elapsed       <= '0;
      probe_first   <= PROBE_FIRST_RST;
      probe_retry   <= PROBE_RETRY_RST;
      sweep_period  <= SWEEP_RST;
      slot_active   <= '0;
      slot_reserved <= '0;
      slot_armed    <= '0;
      held_valid    <= 1'b0;
      m_valid       <= 1'b0;
      out_last      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROBE_FIRST: probe_first  <= cfg_data;
          CFG_PROBE_RETRY: probe_retry  <= cfg_data;
          CFG_SWEEP:       sweep_period <= cfg_data;
          default:         sweep_period <= sweep_period;
        endcase
      end

      if (out_load) begin
        m_valid  <= 1'b1;
        out_r    <= held;
        out_last <= (state == S_FLUSH);
      end else if (m_valid && m_tready) begin
        m_valid <= 1'b0;
      end

      if (commit_we) begin
        slot_reserved[commit_addr] <= 1'b0;
        slot_armed[commit_addr]    <= in_flags[0];
      end

      mod_go <= (state == S_IDLE) && s_tvalid && (s_tuser == A_TICK);

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_r       <= s_tdata[IN_USED_W-1:0];
            act_r      <= s_tuser;
            idx        <= '0;
            res_cnt    <= '0;
            probe_pass <= 1'b0;
            if (s_tuser == A_REGISTER || s_tuser == A_RESERVE) begin
              state <= S_FIND;
            end else if (s_tuser == A_COMMIT || s_tuser == A_RELEASE) begin
              state <= S_COMMIT;
            end else if (s_tuser == A_REPORT || s_tuser == A_DEFAULT) begin
              state <= S_RD;
            end else if (s_tuser == A_TICK) begin
              elapsed <= elapsed + 1'b1;
              state   <= S_MOD;
            end
          end
        end
        S_FIND: begin
          if (find_free) begin
            slot_active[idx] <= 1'b1;
            if (act_r != A_REGISTER) begin
              slot_reserved[idx] <= 1'b1;
              slot_armed[idx]    <= 1'b0;
            end
          end
          if (find_free || idx == LAST_SLOT) begin
            held       <= reply_res;
            held_valid <= 1'b1;
            state      <= S_FLUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_COMMIT: begin
          if (act_r == A_RELEASE && in_slot_ok &&
              slot_active[in_addr] && slot_reserved[in_addr]) begin
            slot_active[in_addr]   <= 1'b0;
            slot_reserved[in_addr] <= 1'b0;
            slot_armed[in_addr]    <= 1'b0;
          end
          state <= S_IDLE;
        end
        S_MOD: begin
          if (mod_done) begin
            probe_pass <= !mod_zero;
            idx        <= '0;
            state      <= S_RD;
          end
        end
        S_RD: begin
          if (res_cnt == RES_CNT_W'(MAX_RESULTS)) begin
            if (act_r == A_TICK && !probe_pass) begin
              probe_pass <= 1'b1;
              idx        <= '0;
            end else begin
              state <= S_FLUSH;
            end
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (advance) begin
            if (push) begin
              held       <= ev_res;
              held_valid <= 1'b1;
              res_cnt    <= res_cnt + 1'b1;
            end
            if (ev_free) begin
              slot_active[idx]   <= 1'b0;
              slot_reserved[idx] <= 1'b0;
              slot_armed[idx]    <= 1'b0;
            end
            if (idx != LAST_SLOT) begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end else if (act_r == A_TICK && !probe_pass) begin
              probe_pass <= 1'b1;
              idx        <= '0;
              state      <= S_RD;
            end else begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!held_valid || out_free) begin
            held_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (slot_reserved & ~slot_active) == '0)
    else $error("reserved slot not active");

  assert property (@(posedge clk) disable iff (rst)
    (slot_armed & ~slot_active) == '0)
    else $error("armed slot not active");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !held_valid)
    else $error("result left behind at end of transaction");

  assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_CNT_W'(MAX_RESULTS))
    else $error("result count overrun");

  assert property (@(posedge clk) disable iff (rst)
    (out_load && m_valid) |-> m_tready)
    else $error("output register overwritten");

endmodule
